// File: hw/rtl/vtpy_pkg.sv
// ----------------------------------------------------------------------------
// vtpy_pkg: types, constants and step functions for vector_to_pitch_yaw
// Fixed-point formats, the CORDIC micro-rotation, the square root digit step
// and the per-step arctangent constants in degrees.
// ----------------------------------------------------------------------------
package vtpy_pkg;

   localparam int IN_W        = 32;             // input components, Q16.16
   localparam int GUARD_BITS  = 24;             // datapath scale-up
   localparam int DP_W        = IN_W + GUARD_BITS + 4;
   localparam int ANG_FRAC    = 32;             // angle accumulator, Q.32 degrees
   localparam int ANG_W       = ANG_FRAC + 10;  // holds +-512 degrees
   localparam int SQ_W        = 2 * IN_W;       // x^2 + y^2
   localparam int ROOT_STEPS  = IN_W;           // one root bit per stage
   localparam int DEG_INT_W   = 9;              // integer bits of an output angle

   localparam longint DEG_PER_RAD_Q32 = 64'sd246083499208;

   localparam int FULL_TURN_DEG    = 360;
   localparam int QUARTER_TURN_DEG = 90;
   localparam int PITCH_UP_DEG     = 270;
   localparam int PITCH_DOWN_DEG   = 90;

   typedef logic signed [IN_W-1:0]  coord_type;
   typedef logic signed [DP_W-1:0]  dp_type;
   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic        [SQ_W-1:0]  sq_type;

   typedef struct packed {
      logic hz;      // x and y both zero
      logic z_pos;   // z above zero
   } flag_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      flag_type  flags;
   } side_type;

   typedef struct packed {
      sq_type n;
      sq_type res;
   } root_type;

   typedef struct packed {
      dp_type  x;
      dp_type  y;
      ang_type z;
   } lane_type;

   // atan(2^-i) in degrees, Q.32, from the truncated series
   function automatic ang_type atan_step(int i);
      longint acc;
      acc = 0;
      if (i == 0) begin
         acc = longint'(45) <<< ANG_FRAC;
      end else begin
         if ( 1 * i < 40) acc += (DEG_PER_RAD_Q32 >>> ( 1 * i));
         if ( 3 * i < 40) acc -= (DEG_PER_RAD_Q32 >>> ( 3 * i)) / 3;
         if ( 5 * i < 40) acc += (DEG_PER_RAD_Q32 >>> ( 5 * i)) / 5;
         if ( 7 * i < 40) acc -= (DEG_PER_RAD_Q32 >>> ( 7 * i)) / 7;
         if ( 9 * i < 40) acc += (DEG_PER_RAD_Q32 >>> ( 9 * i)) / 9;
         if (11 * i < 40) acc -= (DEG_PER_RAD_Q32 >>> (11 * i)) / 11;
         if (13 * i < 40) acc += (DEG_PER_RAD_Q32 >>> (13 * i)) / 13;
         if (15 * i < 40) acc -= (DEG_PER_RAD_Q32 >>> (15 * i)) / 15;
         if (17 * i < 40) acc += (DEG_PER_RAD_Q32 >>> (17 * i)) / 17;
         if (19 * i < 40) acc -= (DEG_PER_RAD_Q32 >>> (19 * i)) / 19;
         if (21 * i < 40) acc += (DEG_PER_RAD_Q32 >>> (21 * i)) / 21;
         if (23 * i < 40) acc -= (DEG_PER_RAD_Q32 >>> (23 * i)) / 23;
         if (25 * i < 40) acc += (DEG_PER_RAD_Q32 >>> (25 * i)) / 25;
         if (27 * i < 40) acc -= (DEG_PER_RAD_Q32 >>> (27 * i)) / 27;
         if (29 * i < 40) acc += (DEG_PER_RAD_Q32 >>> (29 * i)) / 29;
         if (31 * i < 40) acc -= (DEG_PER_RAD_Q32 >>> (31 * i)) / 31;
         if (33 * i < 40) acc += (DEG_PER_RAD_Q32 >>> (33 * i)) / 33;
         if (35 * i < 40) acc -= (DEG_PER_RAD_Q32 >>> (35 * i)) / 35;
         if (37 * i < 40) acc += (DEG_PER_RAD_Q32 >>> (37 * i)) / 37;
         if (39 * i < 40) acc -= (DEG_PER_RAD_Q32 >>> (39 * i)) / 39;
      end
      return ang_type'(acc);
   endfunction

   // one restoring square root digit, trial bit 2^(62 - 2*step)
   function automatic root_type root_step(root_type cur, int step);
      sq_type   bit_val;
      sq_type   trial;
      root_type nxt;
      bit_val = sq_type'(1) << (SQ_W - 2 - 2 * step);
      trial   = cur.res + bit_val;
      if (cur.n >= trial) begin
         nxt.n   = cur.n - trial;
         nxt.res = (cur.res >> 1) + bit_val;
      end else begin
         nxt.n   = cur.n;
         nxt.res = cur.res >> 1;
      end
      return nxt;
   endfunction

   // left half-plane folded into the right by a quarter turn
   function automatic lane_type pre_rotate(dp_type x, dp_type y);
      lane_type l;
      l.x = x;
      l.y = y;
      l.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            l.x = y;
            l.y = -x;
            l.z = ang_type'(QUARTER_TURN_DEG) <<< ANG_FRAC;
         end else begin
            l.x = -y;
            l.y = x;
            l.z = -(ang_type'(QUARTER_TURN_DEG) <<< ANG_FRAC);
         end
      end
      return l;
   endfunction

   // vectoring micro-rotation i, drives y towards zero
   function automatic lane_type cordic_step(lane_type cur, int i);
      lane_type nxt;
      dp_type   dx;
      dp_type   dy;
      ang_type  a;
      dx = cur.y >>> i;
      dy = cur.x >>> i;
      a  = atan_step(i);
      if (!cur.y[DP_W-1]) begin
         nxt.x = cur.x + dx;
         nxt.y = cur.y - dy;
         nxt.z = cur.z + a;
      end else begin
         nxt.x = cur.x - dx;
         nxt.y = cur.y + dy;
         nxt.z = cur.z - a;
      end
      return nxt;
   endfunction

endpackage

// File: hw/rtl/vector_to_pitch_yaw.sv
// ----------------------------------------------------------------------------
// vector_to_pitch_yaw: direction vector to yaw and pitch angles
// Fully pipelined: squares, a bit-per-stage square root, then two CORDIC
// vectoring lanes side by side and a rounding/wrap stage.
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   -------------------------
//  request   req_vec_x, req_vec_y, req_vec_z         start && !busy
//  result    rsp_pitch_deg, rsp_yaw_deg              rsp_valid, one cycle
//
//  One request may enter every cycle; busy is held low.
//  Stages: one squaring stage, one sum stage, 32 square root stages, one
//  fold stage, ITERATIONS CORDIC stages and one output stage.  The square
//  root chain is the largest part that does not depend on ITERATIONS.
//  Synchronous reset clears the valid bits only; payload is not reset.
//  The receiver cannot stall, so the pipeline never holds.
//
module vector_to_pitch_yaw #(
   parameter int ITERATIONS = 24,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  vtpy_pkg::coord_type                    req_vec_x,
   input  vtpy_pkg::coord_type                    req_vec_y,
   input  vtpy_pkg::coord_type                    req_vec_z,
   output logic                                   rsp_valid,
   output logic [vtpy_pkg::DEG_INT_W+FRAC_BITS-1:0] rsp_pitch_deg,
   output logic [vtpy_pkg::DEG_INT_W+FRAC_BITS-1:0] rsp_yaw_deg
);
   import vtpy_pkg::*;

   localparam int OUT_W   = DEG_INT_W + FRAC_BITS;
   localparam int Q_W     = ANG_W - (ANG_FRAC - FRAC_BITS);    // rounded angle, signed
   localparam int LATENCY = ITERATIONS + ROOT_STEPS + 4;

   localparam logic signed [Q_W-1:0] FULL_Q   = Q_W'(FULL_TURN_DEG) <<< FRAC_BITS;
   localparam logic [OUT_W-1:0]      FULL_OUT = OUT_W'(FULL_TURN_DEG) << FRAC_BITS;
   localparam logic [OUT_W-1:0]      UP_OUT   = OUT_W'(PITCH_UP_DEG) << FRAC_BITS;
   localparam logic [OUT_W-1:0]      DOWN_OUT = OUT_W'(PITCH_DOWN_DEG) << FRAC_BITS;

   // Q.32 degrees -> rounded half up, wrapped into [0,360)
   function automatic logic [OUT_W-1:0] to_output(ang_type z);
      ang_type                zr;
      logic signed [Q_W-1:0]  q;
      zr = z + (ang_type'(1) <<< (ANG_FRAC - 1 - FRAC_BITS));
      q  = Q_W'(zr >>> (ANG_FRAC - FRAC_BITS));
      if (q < 0) q = q + FULL_Q;
      if (q >= FULL_Q) q = q - FULL_Q;
      return q[OUT_W-1:0];
   endfunction

   // never stalls
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // stage A: squares of x and y, side data captured
   // ---------------------------------------------------------------------
   logic                   a_valid_ff;
   logic signed [SQ_W-1:0] a_sqx_in;
   logic signed [SQ_W-1:0] a_sqy_in;
   sq_type                 a_sqx_ff;
   sq_type                 a_sqy_ff;
   side_type               a_side_in;
   side_type               a_side_ff;

   always_comb begin
      a_sqx_in          = SQ_W'(req_vec_x) * SQ_W'(req_vec_x);
      a_sqy_in          = SQ_W'(req_vec_y) * SQ_W'(req_vec_y);
      a_side_in.x       = req_vec_x;
      a_side_in.y       = req_vec_y;
      a_side_in.z       = req_vec_z;
      a_side_in.flags.hz    = (req_vec_x == '0) && (req_vec_y == '0);
      a_side_in.flags.z_pos = (req_vec_z > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      a_sqx_ff  <= sq_type'(a_sqx_in);
      a_sqy_ff  <= sq_type'(a_sqy_in);
      a_side_ff <= a_side_in;
   end

   // ---------------------------------------------------------------------
   // square root chain: entry 0 holds x^2 + y^2, entry s the s-th digit
   // ---------------------------------------------------------------------
   logic     [ROOT_STEPS:0] sq_valid_in;
   logic     [ROOT_STEPS:0] sq_valid_ff;
   root_type                sq_root_in [0:ROOT_STEPS];
   root_type                sq_root_ff [0:ROOT_STEPS];
   side_type                sq_side_in [0:ROOT_STEPS];
   side_type                sq_side_ff [0:ROOT_STEPS];

   assign sq_valid_in       = {sq_valid_ff[ROOT_STEPS-1:0], a_valid_ff};
   assign sq_root_in[0].n   = a_sqx_ff + a_sqy_ff;
   assign sq_root_in[0].res = '0;
   assign sq_side_in[0]     = a_side_ff;

   for (genvar s = 1; s <= ROOT_STEPS; s++) begin : g_root
      assign sq_root_in[s] = root_step(sq_root_ff[s-1], s - 1);
      assign sq_side_in[s] = sq_side_ff[s-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= '0;
      end else begin
         sq_valid_ff <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= ROOT_STEPS; s++) begin
         sq_root_ff[s] <= sq_root_in[s];
         sq_side_ff[s] <= sq_side_in[s];
      end
   end

   // ---------------------------------------------------------------------
   // CORDIC lanes: entry 0 is the scaled, folded vector; entry i+1 follows
   // micro-rotation i.  Yaw works on (x, y), pitch on (r, -z).
   // ---------------------------------------------------------------------
   logic      [ITERATIONS:0] cv_valid_in;
   logic      [ITERATIONS:0] cv_valid_ff;
   lane_type                 cv_yaw_in   [0:ITERATIONS];
   lane_type                 cv_yaw_ff   [0:ITERATIONS];
   lane_type                 cv_pitch_in [0:ITERATIONS];
   lane_type                 cv_pitch_ff [0:ITERATIONS];
   flag_type                 cv_flags_in [0:ITERATIONS];
   flag_type                 cv_flags_ff [0:ITERATIONS];
   logic      [IN_W-1:0]     root_val;
   side_type                 root_side;

   assign root_val  = sq_root_ff[ROOT_STEPS].res[IN_W-1:0];
   assign root_side = sq_side_ff[ROOT_STEPS];

   assign cv_valid_in    = {cv_valid_ff[ITERATIONS-1:0], sq_valid_ff[ROOT_STEPS]};
   assign cv_yaw_in[0]   = pre_rotate(dp_type'(root_side.x) <<< GUARD_BITS,
                                      dp_type'(root_side.y) <<< GUARD_BITS);
   assign cv_pitch_in[0] = pre_rotate(dp_type'({1'b0, root_val}) <<< GUARD_BITS,
                                      -(dp_type'(root_side.z) <<< GUARD_BITS));
   assign cv_flags_in[0] = root_side.flags;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_cordic
      assign cv_yaw_in[i+1]   = cordic_step(cv_yaw_ff[i], i);
      assign cv_pitch_in[i+1] = cordic_step(cv_pitch_ff[i], i);
      assign cv_flags_in[i+1] = cv_flags_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_valid_ff <= '0;
      end else begin
         cv_valid_ff <= cv_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= ITERATIONS; i++) begin
         cv_yaw_ff[i]   <= cv_yaw_in[i];
         cv_pitch_ff[i] <= cv_pitch_in[i];
         cv_flags_ff[i] <= cv_flags_in[i];
      end
   end

   // ---------------------------------------------------------------------
   // output stage: rounding, wrap, and the straight up / down case
   // ---------------------------------------------------------------------
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_pitch_in;
   logic [OUT_W-1:0] rsp_pitch_ff;
   logic [OUT_W-1:0] rsp_yaw_in;
   logic [OUT_W-1:0] rsp_yaw_ff;
   flag_type         out_flags;

   assign out_flags = cv_flags_ff[ITERATIONS];

   always_comb begin
      if (out_flags.hz) begin
         // no horizontal part: yaw is zero, pitch points straight up or down
         rsp_yaw_in   = '0;
         rsp_pitch_in = out_flags.z_pos ? UP_OUT : DOWN_OUT;
      end else begin
         rsp_yaw_in   = to_output(cv_yaw_ff[ITERATIONS].z);
         rsp_pitch_in = to_output(cv_pitch_ff[ITERATIONS].z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cv_valid_ff[ITERATIONS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_yaw_ff   <= rsp_yaw_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pitch_deg = rsp_pitch_ff;
   assign rsp_yaw_deg   = rsp_yaw_ff;

`ifndef SYNTHESIS
   // every result traces back to a request that entered the pipeline
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching request");

   // wrapped angles stay below a full turn
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_deg < FULL_OUT) && (rsp_pitch_deg < FULL_OUT))
      else $error("angle not wrapped below 360");

   // zero horizontal part gives zero yaw
   a_zero_yaw : assert property (@(posedge clock) disable iff (reset)
      (cv_valid_ff[ITERATIONS] && out_flags.hz) |=> (rsp_yaw_deg == '0))
      else $error("yaw not zero for vertical vector");

   // square root of a 64-bit sum fits the lower half
   a_root_width : assert property (@(posedge clock) disable iff (reset)
      sq_valid_ff[ROOT_STEPS] |-> (sq_root_ff[ROOT_STEPS].res[SQ_W-1:IN_W] == '0))
      else $error("square root overflowed");
`endif

endmodule

// File: bench/vector_to_pitch_yaw_tb.sv
// ----------------------------------------------------------------------------
// vector_to_pitch_yaw_tb: self-checking bench for vector_to_pitch_yaw
// Sends direction vectors, predicts yaw and pitch with a CORDIC model of the datapath
// kept in the bench or takes them typed in, and checks every result in order of arrival.
// ----------------------------------------------------------------------------
module vector_to_pitch_yaw_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import vtpy_pkg::*;

   localparam int ITERATIONS  = 24;
   localparam int FRAC_BITS   = 16;
   localparam int GUARD       = 24;
   localparam int LATENCY     = ITERATIONS + 36;
   localparam int RAND_ITEMS  = 700;
   localparam int CYCLE_LIMIT = 200000;

   typedef logic [DEG_INT_W+FRAC_BITS-1:0] deg_type;

   typedef struct packed {
      deg_type pitch;
      deg_type yaw;
   } pitch_yaw_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      known;   // expectation typed in below
      deg_type   pitch;
      deg_type   yaw;
   } vec_row_type;

   localparam coord_type C_MAX = 32'sh7FFF_FFFF;
   localparam coord_type C_MIN = 32'sh8000_0000;
   localparam coord_type C_ONE = 32'sh0001_0000;   // 1.0 in Q16.16
   localparam coord_type C_NEG = -32'sh0001_0000;

   // straight up / straight down when there is no horizontal part
   localparam deg_type UP_DEG   = deg_type'(PITCH_UP_DEG) << FRAC_BITS;
   localparam deg_type DOWN_DEG = deg_type'(PITCH_DOWN_DEG) << FRAC_BITS;

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      start     = 1'b0;
   coord_type req_vec_x = '0;
   coord_type req_vec_y = '0;
   coord_type req_vec_z = '0;
   logic      busy;
   logic      rsp_valid;
   deg_type   rsp_pitch_deg;
   deg_type   rsp_yaw_deg;

   pitch_yaw_type angles_due [$];   // predicted angles, oldest first
   int         cycle_count  = 0;
   int         faults       = 0;
   int         requests     = 0;
   int         results_seen = 0;
   int         no_horiz     = 0;   // requests with x == y == 0
   int         left_half    = 0;   // requests with x < 0
   int         idle_pct [4] = '{0, 75, 0, 27};

   // directed requests: zero horizontal part, folds, extremes, wrap to 0
   vec_row_type dir_table [24] = '{
      '{32'sd0, 32'sd0, 32'sd0,  1'b1, DOWN_DEG, '0},
      '{32'sd0, 32'sd0, 32'sd1,  1'b1, UP_DEG,   '0},
      '{32'sd0, 32'sd0, -32'sd1, 1'b1, DOWN_DEG, '0},
      '{32'sd0, 32'sd0, C_MAX,   1'b1, UP_DEG,   '0},
      '{32'sd0, 32'sd0, C_MIN,   1'b1, DOWN_DEG, '0},
      '{C_ONE,  32'sd0, 32'sd0,  1'b0, '0, '0},
      '{32'sd0, C_ONE,  32'sd0,  1'b0, '0, '0},
      '{C_NEG,  32'sd0, 32'sd0,  1'b0, '0, '0},
      '{32'sd0, C_NEG,  32'sd0,  1'b0, '0, '0},
      '{C_NEG,  -32'sd1, 32'sd0, 1'b0, '0, '0},
      '{C_MAX,  C_MAX,  C_MAX,   1'b0, '0, '0},
      '{C_MIN,  C_MIN,  C_MIN,   1'b0, '0, '0},
      '{C_MIN,  32'sd0, C_MAX,   1'b0, '0, '0},
      '{C_MIN,  -32'sd1, C_MIN,  1'b0, '0, '0},
      '{C_MAX,  -32'sd1, 32'sd0, 1'b0, '0, '0},
      '{C_MAX,  32'sd0, 32'sd1,  1'b0, '0, '0},
      '{32'sd1, 32'sd0, 32'sd0,  1'b0, '0, '0},
      '{-32'sd1, -32'sd1, -32'sd1, 1'b0, '0, '0},
      '{32'sd0, C_MIN,  32'sd0,  1'b0, '0, '0},
      '{C_ONE,  C_ONE,  C_NEG,   1'b0, '0, '0},
      '{C_ONE,  32'sd0, C_MIN,   1'b0, '0, '0},
      '{C_ONE,  32'sd0, C_MAX,   1'b0, '0, '0},
      '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5A5A_5A5A, 1'b0, '0, '0},
      '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shA5A5_A5A5, 1'b0, '0, '0}
   };

   vector_to_pitch_yaw #(
      .ITERATIONS (ITERATIONS),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .rsp_valid     (rsp_valid),
      .rsp_pitch_deg (rsp_pitch_deg),
      .rsp_yaw_deg   (rsp_yaw_deg)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------- model

   // arctangent of 2^-i in degrees, Q.32, truncated odd series
   function automatic longint micro_angle(int i);
      longint acc;
      longint term;
      acc = 0;
      if (i == 0) begin
         return longint'(45) << 32;
      end
      for (int k = 0; i * (2 * k + 1) < 40; k++) begin
         term = (DEG_PER_RAD_Q32 >>> (i * (2 * k + 1))) / (2 * k + 1);
         if (k % 2 == 1) begin
            acc -= term;
         end else begin
            acc += term;
         end
      end
      return acc;
   endfunction

   // floor square root, two bits of the radicand per pass
   function automatic bit [63:0] floor_root(bit [63:0] n);
      bit [63:0] res;
      bit [63:0] b;
      res = '0;
      b   = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n   = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // CORDIC vectoring: angle of (x, y) in degrees, Q.32
   function automatic longint vector_bearing(longint x, longint y);
      longint ang;
      longint t;
      longint dx;
      longint dy;
      ang = 0;
      if (x < 0) begin
         // quarter turn into the right half-plane
         t = x;
         if (y >= 0) begin
            x   = y;
            y   = -t;
            ang = longint'(QUARTER_TURN_DEG) << 32;
         end else begin
            x   = -y;
            y   = t;
            ang = -(longint'(QUARTER_TURN_DEG) << 32);
         end
      end
      for (int i = 0; i < ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x   = x + dx;
            y   = y - dy;
            ang = ang + micro_angle(i);
         end else begin
            x   = x - dx;
            y   = y + dy;
            ang = ang - micro_angle(i);
         end
      end
      return ang;
   endfunction

   // round half up to FRAC_BITS, then wrap into [0, 360)
   function automatic deg_type wrap_degrees(longint a);
      longint q;
      longint turn;
      turn = longint'(FULL_TURN_DEG) << FRAC_BITS;
      q    = (a + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
      if (q < 0) q += turn;
      if (q >= turn) q -= turn;
      return deg_type'(q);
   endfunction

   function automatic pitch_yaw_type predict_angles(coord_type vx, coord_type vy,
                                                    coord_type vz);
      pitch_yaw_type res;
      longint        x;
      longint        y;
      longint        z;
      bit [63:0]     rsq;
      longint        r;
      x = longint'(vx);
      y = longint'(vy);
      z = longint'(vz);
      if (x == 0 && y == 0) begin
         res.pitch = (z > 0) ? UP_DEG : DOWN_DEG;
         res.yaw   = '0;
         return res;
      end
      rsq = x * x;
      rsq = rsq + y * y;
      r   = longint'(floor_root(rsq));
      res.yaw   = wrap_degrees(vector_bearing(x <<< GUARD, y <<< GUARD));
      res.pitch = wrap_degrees(vector_bearing(r <<< GUARD, (-z) <<< GUARD));
      return res;
   endfunction

   // ------------------------------------------------------------- stimulus

   // component mix: full range, near zero, exact zero, extremes, mid range
   function automatic coord_type pick_coord();
      case ($urandom_range(5))
         0, 1:    return coord_type'($urandom);
         2:       return coord_type'($urandom_range(0, 32'h0002_0000))
                         - coord_type'(32'h0001_0000);
         3:       return '0;
         4: begin
            case ($urandom_range(3))
               0:       return C_MAX;
               1:       return C_MIN;
               2:       return 32'sd1;
               default: return -32'sd1;
            endcase
         end
         default: return coord_type'($urandom) >>> $urandom_range(1, 24);
      endcase
   endfunction

   // hold the request until it is taken; the edge that takes it is the one
   // whose sampled busy is low
   task automatic issue_vector(coord_type x, coord_type y, coord_type z,
                               logic known, deg_type pitch, deg_type yaw);
      pitch_yaw_type due;
      start     <= 1'b1;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      do @(posedge clock); while (busy !== 1'b0);
      if (known) begin
         due.pitch = pitch;
         due.yaw   = yaw;
      end else begin
         due = predict_angles(x, y, z);
      end
      angles_due.push_back(due);
      requests++;
      if (x == 0 && y == 0) no_horiz++;
      if (x < 0) left_half++;
   endtask

   task automatic sender_gap(int pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // --------------------------------------------------------------- checker

   always @(posedge clock) begin
      pitch_yaw_type due;
      if (!reset && rsp_valid !== 1'b0) begin
         results_seen++;
         if (angles_due.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result: pitch %0d yaw %0d at cycle %0d",
                        rsp_pitch_deg, rsp_yaw_deg, cycle_count);
         end else begin
            due = angles_due.pop_front();
            if (rsp_pitch_deg !== due.pitch || rsp_yaw_deg !== due.yaw) begin
               faults++;
               if (faults <= 10)
                  $display("mismatch at cycle %0d: pitch exp %0d got %0d, yaw exp %0d got %0d",
                           cycle_count, due.pitch, rsp_pitch_deg,
                           due.yaw, rsp_yaw_deg);
            end
         end
      end
   end

   // --------------------------------------------------------------- timeout

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, angles_due.size());
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------- main flow

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests back to back
      foreach (dir_table[i]) begin
         issue_vector(dir_table[i].x, dir_table[i].y, dir_table[i].z,
                      dir_table[i].known, dir_table[i].pitch, dir_table[i].yaw);
      end

      // random phases; each begins with the sender holding off until the
      // pipeline has drained, so requests also meet an empty pipeline
      for (int phase = 0; phase < 4; phase++) begin
         start <= 1'b0;
         while (angles_due.size() != 0) @(posedge clock);
         for (int n = 0; n < RAND_ITEMS / 4; n++) begin
            sender_gap(idle_pct[phase]);
            issue_vector(pick_coord(), pick_coord(), pick_coord(),
                         1'b0, '0, '0);
         end
      end

      start <= 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
      // let any stray result show up
      repeat (LATENCY + 8) @(posedge clock);

      $display("%0d requests (%0d with no horizontal part, %0d in the left half-plane),",
               requests, no_horiz, left_half);
      $display("%0d results checked over four sender idling phases", results_seen);
      if (faults == 0 && angles_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d faults", faults);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/vtpy_pkg.sv
hw/rtl/vector_to_pitch_yaw.sv
bench/vector_to_pitch_yaw_tb.sv
